// File: rtl/uudecode_line_stream_defines.svh
// Assertion macros shared by the uudecode line stream RTL.
`ifndef UUDECODE_LINE_STREAM_DEFINES_SVH
`define UUDECODE_LINE_STREAM_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while arst_n is low.
`define UUD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, quiet while arst_n is low.
`define UUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/uud_pkg.sv
// Shared constants, types and helper functions for the uudecode line stream.
`timescale 1ns / 1ps

package uud_pkg;

	localparam int MAX_LINE_BYTES = 45;
	localparam int ADDR_BITS      = 24;

	localparam logic [63:0] ADDR_MASK_W = (64'd1 << ADDR_BITS) - 64'd1;
	localparam logic [23:0] ADDR_MASK   = ADDR_MASK_W[23:0];

	localparam logic [23:0] LOAD_BASE_RST = 24'h008000;

	// register index decoded from paddr[2]
	localparam logic REG_LOAD_BASE = 1'b0;

	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_DATA_MAX = 8'h5F;
	localparam logic [7:0] CASE_BIT      = 8'h20;
	localparam logic [7:0] MAX_COUNT     = 8'(MAX_LINE_BYTES);

	// download phase
	localparam logic [1:0] PH_WAIT   = 2'd0;
	localparam logic [1:0] PH_DECODE = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// position within the current line
	localparam logic [1:0] LN_START = 2'd0;
	localparam logic [1:0] LN_DATA  = 2'd1;
	localparam logic [1:0] LN_SKIP  = 2'd2;

	localparam logic [2:0] BEGIN_LEN = 3'd5;
	localparam logic [2:0] END_LEN   = 3'd3;

	typedef struct packed {
		logic       load_item;
		logic       wait_eol;
		logic       wait_chr;
		logic       hold_chr;
		logic       kill_match;
		logic       data_step;
		logic       data_sel_held;
		logic [1:0] held_idx;
		logic       pad_step;
		logic       emit_byte;
		logic [1:0] byte_idx;
		logic       emit_last;
		logic       emit_sum;
		logic       new_line;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [1:0] line_phase;
		logic       match_alive;
		logic [2:0] match_pos;
		logic       eol;
		logic       end_hit;
		logic       ch_le_space;
		logic       group_done;
		logic       sextet_full;
		logic       bytes_left_one;
		logic       out_free;
	} dp_sts_t;

	function automatic logic [7:0] begin_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h62;
			3'd1:    c = 8'h65;
			3'd2:    c = 8'h67;
			3'd3:    c = 8'h69;
			3'd4:    c = 8'h6E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] end_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h65;
			3'd1:    c = 8'h6E;
			3'd2:    c = 8'h64;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/uud_ctrl.sv
// Sequencer for the uudecode line stream: steps each item through the datapath.
`timescale 1ns / 1ps
`include "uudecode_line_stream_defines.svh"

module uud_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  uud_pkg::dp_sts_t   sts,
	output uud_pkg::ctrl_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_REPLAY = 3'd2;
	localparam logic [2:0] S_CHAR   = 3'd3;
	localparam logic [2:0] S_PAD    = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] idx_q, idx_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_IDLE;
				case (sts.phase)
					uud_pkg::PH_WAIT: begin
						if (sts.eol) begin
							cmd.wait_eol = 1'b1;
							cmd.new_line = 1'b1;
						end else begin
							cmd.wait_chr = 1'b1;
						end
					end
					uud_pkg::PH_DECODE: begin
						if (sts.eol) begin
							if (sts.match_alive) begin
								if (sts.match_pos == uud_pkg::END_LEN) begin
									state_d = S_FIN;
								end else begin
									cmd.kill_match = 1'b1;
									idx_d          = 2'd0;
									state_d        = S_REPLAY;
								end
							end else begin
								state_d = S_PAD;
							end
						end else if (sts.match_alive) begin
							if (sts.match_pos < uud_pkg::END_LEN && sts.end_hit) begin
								cmd.hold_chr = 1'b1;
							end else if (sts.match_pos == uud_pkg::END_LEN &&
								sts.ch_le_space) begin
								state_d = S_FIN;
							end else begin
								cmd.kill_match = 1'b1;
								idx_d          = 2'd0;
								state_d        = S_REPLAY;
							end
						end else begin
							// plain character: decode it in this cycle
							cmd.data_step = 1'b1;
							if (sts.group_done) begin
								idx_d   = 2'd0;
								state_d = S_EMIT;
							end
						end
					end
					default: ;
				endcase
			end
			S_REPLAY: begin
				// feed the held start of a line that turned out not to be an end line
				if (3'(idx_q) == sts.match_pos) begin
					state_d = sts.eol ? S_PAD : S_CHAR;
				end else begin
					cmd.data_step     = 1'b1;
					cmd.data_sel_held = 1'b1;
					cmd.held_idx      = idx_q;
					idx_d             = idx_q + 2'd1;
				end
			end
			S_CHAR: begin
				cmd.data_step = 1'b1;
				idx_d         = 2'd0;
				state_d       = sts.group_done ? S_EMIT : S_IDLE;
			end
			S_PAD: begin
				if (sts.line_phase != uud_pkg::LN_DATA) begin
					cmd.new_line = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.pad_step = 1'b1;
					if (sts.sextet_full) begin
						idx_d   = 2'd0;
						state_d = S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					cmd.byte_idx  = idx_q;
					cmd.emit_last = sts.bytes_left_one || (idx_q == 2'd2 && !sts.eol);
					if (sts.bytes_left_one) begin
						cmd.new_line = sts.eol;
						state_d      = S_IDLE;
					end else if (idx_q == 2'd2) begin
						state_d = sts.eol ? S_PAD : S_IDLE;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.emit_sum = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	`UUD_ASSERT_NOW(a_replay_in_range, state_q == S_REPLAY, 3'(idx_q) <= sts.match_pos, "replay index past held characters")
	`UUD_ASSERT_NOW(a_emit_in_group, state_q == S_EMIT, idx_q != 2'd3, "byte index outside a group")
	`UUD_ASSERT_NOW(a_emit_has_room, cmd.emit_byte || cmd.emit_sum, sts.out_free, "result issued into a full output register")
	`UUD_ASSERT_NEXT(a_accept_eval, item_valid && !item_stall, state_q == S_EVAL, "accepted item not evaluated")

endmodule

// File: rtl/uud_dp.sv
// Datapath for the uudecode line stream: line state, sextet decode, counters, result register.
`timescale 1ns / 1ps
`include "uudecode_line_stream_defines.svh"

module uud_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  uud_pkg::ctrl_cmd_t cmd,
	output uud_pkg::dp_sts_t   sts,
	input  logic [7:0]         ch,
	input  logic               eol,
	input  logic [23:0]        load_base,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               kind,
	output logic [7:0]         data_byte,
	output logic [23:0]        address,
	output logic [23:0]        total_size,
	output logic [15:0]        error_count,
	output logic               last
);

	// control state
	logic [1:0]  phase_q, phase_d;
	logic [1:0]  line_q, line_d;
	logic [2:0]  pos_q, pos_d;
	logic        alive_q, alive_d;
	logic [5:0]  left_q, left_d;
	logic [1:0]  sext_q, sext_d;
	logic [23:0] offset_q, offset_d;
	logic [15:0] errors_q, errors_d;
	logic        res_valid_q;

	// payload
	logic [7:0]  ch_q;
	logic        eol_q;
	logic [7:0]  held_q [3];
	logic [23:0] acc_q, acc_d;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic [23:0] addr_q;
	logic [23:0] size_q;
	logic [15:0] err_q;
	logic        last_q;

	logic [7:0]  sel_c;
	logic [7:0]  cnt_diff;
	logic        err_inc;
	logic        push_en;
	logic [5:0]  push_val;
	logic        out_free;
	logic        ch_is_data;
	logic [7:0]  emit_val;
	logic [23:0] addr_sum;

	assign out_free   = !res_valid_q || !res_stall;
	assign sel_c      = cmd.data_sel_held ? held_q[cmd.held_idx] : ch_q;
	assign cnt_diff   = sel_c - uud_pkg::CHAR_SPACE;
	assign ch_is_data = (ch_q >= uud_pkg::CHAR_SPACE) && (ch_q <= uud_pkg::CHAR_DATA_MAX);
	assign addr_sum   = load_base + offset_q;

	always_comb begin
		case (cmd.byte_idx)
			2'd0:    emit_val = acc_q[23:16];
			2'd1:    emit_val = acc_q[15:8];
			default: emit_val = acc_q[7:0];
		endcase
	end

	always_comb begin
		sts.phase          = phase_q;
		sts.line_phase     = line_q;
		sts.match_alive    = alive_q;
		sts.match_pos      = pos_q;
		sts.eol            = eol_q;
		sts.end_hit        = (ch_q | uud_pkg::CASE_BIT) == uud_pkg::end_char(pos_q);
		sts.ch_le_space    = ch_q <= uud_pkg::CHAR_SPACE;
		sts.group_done     = (line_q == uud_pkg::LN_DATA) && ch_is_data && (sext_q == 2'd3);
		sts.sextet_full    = sext_q == 2'd3;
		sts.bytes_left_one = left_q == 6'd1;
		sts.out_free       = out_free;
	end

	always_comb begin
		phase_d  = phase_q;
		line_d   = line_q;
		pos_d    = pos_q;
		alive_d  = alive_q;
		left_d   = left_q;
		sext_d   = sext_q;
		offset_d = offset_q;
		err_inc  = 1'b0;
		push_en  = 1'b0;
		push_val = 6'd0;

		if (cmd.wait_eol) begin
			if (alive_q && pos_q == uud_pkg::BEGIN_LEN && line_q != uud_pkg::LN_SKIP) begin
				phase_d = uud_pkg::PH_DECODE;
			end
		end

		if (cmd.wait_chr && alive_q && line_q != uud_pkg::LN_SKIP) begin
			if (pos_q < uud_pkg::BEGIN_LEN) begin
				if ((ch_q | uud_pkg::CASE_BIT) == uud_pkg::begin_char(pos_q)) begin
					pos_d = pos_q + 3'd1;
				end else begin
					alive_d = 1'b0;
				end
			end else if (ch_q <= uud_pkg::CHAR_SPACE) begin
				// rest of the begin line carries mode and name: skip it
				phase_d = uud_pkg::PH_DECODE;
				line_d  = uud_pkg::LN_SKIP;
				alive_d = 1'b0;
			end else begin
				alive_d = 1'b0;
			end
		end

		if (cmd.hold_chr) begin
			pos_d = pos_q + 3'd1;
		end

		if (cmd.kill_match) begin
			alive_d = 1'b0;
		end

		if (cmd.data_step) begin
			case (line_q)
				uud_pkg::LN_START: begin
					if (sel_c == uud_pkg::CHAR_SPACE) begin
						line_d = uud_pkg::LN_SKIP;
					end else if (sel_c < uud_pkg::CHAR_SPACE || cnt_diff > uud_pkg::MAX_COUNT) begin
						err_inc = 1'b1;
						line_d  = uud_pkg::LN_SKIP;
					end else begin
						left_d = cnt_diff[5:0];
						sext_d = 2'd0;
						line_d = uud_pkg::LN_DATA;
					end
				end
				uud_pkg::LN_DATA: begin
					if (sel_c < uud_pkg::CHAR_SPACE || sel_c > uud_pkg::CHAR_DATA_MAX) begin
						err_inc = 1'b1;
						line_d  = uud_pkg::LN_SKIP;
					end else begin
						push_en  = 1'b1;
						push_val = cnt_diff[5:0];
					end
				end
				default: ;
			endcase
		end

		if (cmd.pad_step) begin
			push_en  = 1'b1;
			push_val = 6'd0;
		end

		if (push_en) begin
			sext_d = sext_q + 2'd1;
		end

		if (cmd.emit_byte) begin
			if (offset_q != '1) begin
				offset_d = offset_q + 24'd1;
			end
			left_d = left_q - 6'd1;
			if (left_q == 6'd1) begin
				line_d = uud_pkg::LN_SKIP;
			end
		end

		if (cmd.emit_sum) begin
			phase_d = uud_pkg::PH_DONE;
		end

		// a new line overrides whatever the last byte left behind
		if (cmd.new_line) begin
			line_d  = uud_pkg::LN_START;
			pos_d   = 3'd0;
			alive_d = 1'b1;
		end

		errors_d = errors_q;
		if (err_inc && errors_q != '1) begin
			errors_d = errors_q + 16'd1;
		end

		acc_d = acc_q;
		if (push_en) begin
			acc_d = {acc_q[17:0], push_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uud_pkg::PH_WAIT;
			line_q      <= uud_pkg::LN_START;
			pos_q       <= 3'd0;
			alive_q     <= 1'b1;
			left_q      <= 6'd0;
			sext_q      <= 2'd0;
			offset_q    <= 24'd0;
			errors_q    <= 16'd0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			line_q   <= line_d;
			pos_q    <= pos_d;
			alive_q  <= alive_d;
			left_q   <= left_d;
			sext_q   <= sext_d;
			offset_q <= offset_d;
			errors_q <= errors_d;
			if (cmd.emit_byte || cmd.emit_sum) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			ch_q  <= ch;
			eol_q <= eol;
		end
		if (cmd.hold_chr) begin
			held_q[pos_q[1:0]] <= ch_q;
		end
		acc_q <= acc_d;
		if (cmd.emit_byte) begin
			kind_q <= 1'b0;
			byte_q <= emit_val;
			addr_q <= addr_sum & uud_pkg::ADDR_MASK;
			size_q <= 24'd0;
			err_q  <= errors_q;
			last_q <= cmd.emit_last;
		end else if (cmd.emit_sum) begin
			kind_q <= 1'b1;
			byte_q <= 8'd0;
			addr_q <= load_base;
			size_q <= offset_q;
			err_q  <= errors_q;
			last_q <= 1'b1;
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign data_byte   = byte_q;
	assign address     = addr_q;
	assign total_size  = size_q;
	assign error_count = err_q;
	assign last        = last_q;

	`UUD_ASSERT_NOW(a_summary_last, res_valid_q && kind_q, last_q, "summary result not marked last")
	`UUD_ASSERT_NOW(a_data_has_count, line_q == uud_pkg::LN_DATA, left_q != 6'd0, "data line with no bytes left")
	`UUD_ASSERT_NEXT(a_done_sticks, phase_q == uud_pkg::PH_DONE, phase_q == uud_pkg::PH_DONE, "left finished phase")

endmodule

// File: rtl/uudecode_line_stream.sv
// Top level of the uudecode line stream: register port, sequencer and datapath.
// An ordinary character is accepted and then evaluated; a completed group then emits its bytes in turn.
// At end of line the last group is padded with zero sextets and its remaining bytes are emitted.
// A line held as a possible end line that is not one has its held start replayed through the decoder.
// The first byte of a group is registered from S_EMIT after its character is evaluated, waiting while res_stall holds.
// Reset clears the decode state and sets load_base to 0x8000; no clearing pass is needed.
`timescale 1ns / 1ps

module uudecode_line_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  ch,
	input  logic        eol,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [23:0] address,
	output logic [23:0] total_size,
	output logic [15:0] error_count,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	uud_pkg::ctrl_cmd_t cmd;
	uud_pkg::dp_sts_t   sts;
	logic [23:0]        load_base_q;
	logic               reg_write;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= uud_pkg::LOAD_BASE_RST;
		end else if (reg_write && paddr[2] == uud_pkg::REG_LOAD_BASE) begin
			load_base_q <= pwdata[23:0];
		end
	end

	assign prdata = (paddr[2] == uud_pkg::REG_LOAD_BASE) ? {8'd0, load_base_q} : 32'd0;

	uud_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	uud_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.ch          (ch),
		.eol         (eol),
		.load_base   (load_base_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.address     (address),
		.total_size  (total_size),
		.error_count (error_count),
		.last        (last)
	);

endmodule
